FILE: sv/wgs_pkg.sv
// shared types and constants for the word gap segmenter
package wgs_pkg;

  localparam int unsigned ColMaxW   = 9;   // column count up to 256
  localparam int unsigned AddrMaxW  = 8;   // column address up to 255
  localparam int unsigned ResultCap = 64;  // most word results per line
  localparam int unsigned CapW      = 7;

  localparam logic [2:0] RegFgAddr = 3'd0;

  // column write from the front to the column store
  typedef struct packed {
    logic                en;
    logic [AddrMaxW-1:0] addr;
    logic                ink;
  } wgs_wr_t;

  // line job handed from the front to the back
  typedef struct packed {
    logic               vld;
    logic [ColMaxW-1:0] cols;
    logic               ovf;
  } wgs_job_t;

endpackage

FILE: sv/wgs_front.sv
// front end: takes pixels, marks ink columns, closes lines into jobs
module wgs_front #(
  parameter int unsigned MAX_COLUMNS = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      pixel_i,
  input  logic            column_end_i,
  input  logic            line_end_i,
  input  logic [7:0]      fg_i,
  output wgs_pkg::wgs_wr_t  wr_o,
  output wgs_pkg::wgs_job_t job_o
);
  localparam int unsigned ColW  = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned AddrW = $clog2(MAX_COLUMNS);

  logic            cur_ink_q, cur_ink_d;
  logic [ColW-1:0] col_idx_q, col_idx_d;
  logic            ovf_q, ovf_d;
  logic            ink;
  logic            close_col;
  logic            room;

  assign ink       = cur_ink_q | (pixel_i == fg_i);
  assign close_col = accept_i & (column_end_i | line_end_i);
  assign room      = col_idx_q < ColW'(MAX_COLUMNS);

  always_comb begin
    cur_ink_d = cur_ink_q;
    col_idx_d = col_idx_q;
    ovf_d     = ovf_q;
    wr_o      = '0;
    job_o     = '0;
    if (accept_i) begin
      cur_ink_d = ink;
    end
    if (close_col) begin
      cur_ink_d = 1'b0;
      if (room) begin
        wr_o.en   = 1'b1;
        wr_o.addr = wgs_pkg::AddrMaxW'(col_idx_q[AddrW-1:0]);
        wr_o.ink  = ink;
        col_idx_d = col_idx_q + ColW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (accept_i && line_end_i) begin
      job_o.vld  = 1'b1;
      job_o.cols = wgs_pkg::ColMaxW'(col_idx_d);
      job_o.ovf  = ovf_d;
      col_idx_d  = '0;
      ovf_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_ink_q <= 1'b0;
      col_idx_q <= '0;
      ovf_q     <= 1'b0;
    end else begin
      cur_ink_q <= cur_ink_d;
      col_idx_q <= col_idx_d;
      ovf_q     <= ovf_d;
    end
  end
endmodule

FILE: sv/wgs_div.sv
// iterative restoring divider, one quotient bit per cycle
module wgs_div #(
  parameter int unsigned W = 10
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W-1:0] quo_o
);
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    num_q;
  logic [W-1:0]    den_q;
  logic [W-1:0]    quo_q;
  logic [W:0]      rem_q;
  logic [CntW-1:0] cnt_q;
  logic            run_q;
  logic            done_q;
  logic [W:0]      rem_sh;
  logic            fits;

  assign rem_sh = {rem_q[W-1:0], num_q[W-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(W);
      end else if (run_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (run_q) begin
      num_q <= {num_q[W-2:0], 1'b0};
      rem_q <= fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quo_q <= {quo_q[W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

FILE: sv/wgs_back.sv
// back end: column store, three scans over it, threshold and word output
module wgs_back #(
  parameter int unsigned MAX_COLUMNS = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wgs_pkg::wgs_wr_t  wr_i,
  input  wgs_pkg::wgs_job_t job_i,
  output logic              busy_o,
  output logic              res_vld_o,
  output logic [7:0]        word_left_o,
  output logic [7:0]        word_right_o,
  output logic [8:0]        gap_threshold_o,
  output logic              has_word_o,
  output logic              last_o,
  output logic              too_wide_o
);
  localparam int unsigned ColW  = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned AddrW = $clog2(MAX_COLUMNS);
  localparam int unsigned DW    = ColW + 1;
  localparam int unsigned CapW  = wgs_pkg::CapW;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN1, ST_DIV1, ST_SCAN2, ST_DIV2, ST_SCAN3, ST_FLUSH
  } state_e;

  logic mem_q [MAX_COLUMNS];

  state_e           state_q;
  logic [ColW-1:0]  cols_q;
  logic             ovf_q;
  logic [ColW-1:0]  ra_q;
  logic             rv_q;
  logic             rd_q;
  logic [AddrW-1:0] ri_q;
  logic             seen_q;
  logic [AddrW-1:0] lo_q, hi_q;
  logic [ColW-1:0]  w_q;
  logic [DW-1:0]    sum_q, cnt_q;
  logic [DW-1:0]    avg_ink_q, thr_q;
  logic [AddrW-1:0] wstart_q, prv_q;
  logic             pend_q;
  logic [AddrW-1:0] pend_l_q, pend_r_q;
  logic [CapW-1:0]  n_q;
  logic             out_vld_q, out_has_q, out_last_q;
  logic [AddrW-1:0] out_l_q, out_r_q;

  logic             scanning, scan_done, in_rng;
  logic             div_start, div_done;
  logic [DW-1:0]    div_num, div_den, div_quo, den1, den2, thr_sum;
  logic             cand_vld, put_ok;
  logic [AddrW-1:0] cand_l, cand_r;

  assign scanning  = (state_q == ST_SCAN1) || (state_q == ST_SCAN2) ||
                     (state_q == ST_SCAN3);
  assign scan_done = scanning && (ra_q >= cols_q) && !rv_q;
  assign in_rng    = rv_q && seen_q && (ri_q >= lo_q) && (ri_q <= hi_q);

  // ink runs include a run still open at the end of the first scan
  assign den1 = cnt_q + DW'(w_q != '0);
  assign den2 = (cnt_q == '0) ? DW'(1) : cnt_q;
  always_comb begin
    div_start = 1'b0;
    div_num   = sum_q + DW'(w_q);
    div_den   = (den1 == '0) ? DW'(1) : den1;
    if (state_q == ST_SCAN1 && scan_done) begin
      div_start = 1'b1;
    end else if (state_q == ST_SCAN2 && scan_done) begin
      div_start = 1'b1;
      div_num   = sum_q + den2 - DW'(1);
      div_den   = den2;
    end
  end
  assign thr_sum = avg_ink_q + div_quo + DW'(1);

  wgs_div #(.W(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // word candidate: a split on a wide gap, or the closing word of the line
  always_comb begin
    cand_vld = 1'b0;
    cand_l   = wstart_q;
    cand_r   = prv_q - AddrW'(1);
    if (state_q == ST_SCAN3) begin
      if (scan_done) begin
        cand_vld = seen_q;
        cand_r   = hi_q;
      end else if (in_rng && rd_q && (DW'(w_q) > thr_q)) begin
        cand_vld = 1'b1;
      end
    end
  end
  assign put_ok = cand_vld && (cand_r > cand_l) && (n_q < CapW'(wgs_pkg::ResultCap));

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr[AddrW-1:0]] <= wr_i.ink;
    end
    rd_q <= mem_q[ra_q[AddrW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rv_q      <= 1'b0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
      n_q       <= '0;
    end else begin
      out_vld_q <= 1'b0;
      rv_q      <= 1'b0;
      if (scanning && ra_q < cols_q) begin
        rv_q <= 1'b1;
        ri_q <= ra_q[AddrW-1:0];
        ra_q <= ra_q + ColW'(1);
      end
      case (state_q)
        ST_IDLE: begin
          if (job_i.vld) begin
            cols_q  <= ColW'(job_i.cols);
            ovf_q   <= job_i.ovf;
            ra_q    <= '0;
            seen_q  <= 1'b0;
            w_q     <= '0;
            sum_q   <= '0;
            cnt_q   <= '0;
            n_q     <= '0;
            pend_q  <= 1'b0;
            state_q <= ST_SCAN1;
          end
        end
        ST_SCAN1: begin
          if (rv_q) begin
            if (rd_q) begin
              if (!seen_q) begin
                lo_q <= ri_q;
              end
              seen_q <= 1'b1;
              hi_q   <= ri_q;
              w_q    <= w_q + ColW'(1);
            end else if (w_q != '0) begin
              sum_q <= sum_q + DW'(w_q);
              cnt_q <= cnt_q + DW'(1);
              w_q   <= '0;
            end
          end
          if (scan_done) begin
            state_q <= ST_DIV1;
          end
        end
        ST_DIV1: begin
          if (div_done) begin
            avg_ink_q <= div_quo;
            ra_q      <= '0;
            w_q       <= '0;
            sum_q     <= '0;
            cnt_q     <= '0;
            state_q   <= ST_SCAN2;
          end
        end
        ST_SCAN2: begin
          if (in_rng) begin
            if (!rd_q) begin
              w_q <= w_q + ColW'(1);
            end else begin
              if (DW'(w_q) > avg_ink_q) begin
                sum_q <= sum_q + DW'(w_q);
                cnt_q <= cnt_q + DW'(1);
              end
              w_q <= '0;
            end
          end
          if (scan_done) begin
            state_q <= ST_DIV2;
          end
        end
        ST_DIV2: begin
          if (div_done) begin
            thr_q    <= DW'(thr_sum >> 1);
            ra_q     <= '0;
            w_q      <= '0;
            wstart_q <= lo_q;
            prv_q    <= lo_q;
            state_q  <= ST_SCAN3;
          end
        end
        ST_SCAN3: begin
          if (in_rng) begin
            if (rd_q) begin
              if (DW'(w_q) > thr_q) begin
                wstart_q <= ri_q;
              end
              w_q <= '0;
            end else begin
              if (w_q == '0) begin
                prv_q <= ri_q;
              end
              w_q <= w_q + ColW'(1);
            end
          end
          // hold one word back so the final one can carry last
          if (put_ok) begin
            if (pend_q) begin
              out_vld_q  <= 1'b1;
              out_has_q  <= 1'b1;
              out_last_q <= 1'b0;
              out_l_q    <= pend_l_q;
              out_r_q    <= pend_r_q;
            end
            pend_q   <= 1'b1;
            pend_l_q <= cand_l;
            pend_r_q <= cand_r;
            n_q      <= n_q + CapW'(1);
          end
          if (scan_done) begin
            state_q <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          out_vld_q  <= 1'b1;
          out_has_q  <= pend_q;
          out_last_q <= 1'b1;
          out_l_q    <= pend_q ? pend_l_q : '0;
          out_r_q    <= pend_q ? pend_r_q : '0;
          pend_q     <= 1'b0;
          state_q    <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o          = (state_q != ST_IDLE) || out_vld_q;
  assign res_vld_o       = out_vld_q;
  assign word_left_o     = 8'(out_l_q);
  assign word_right_o    = 8'(out_r_q);
  assign gap_threshold_o = 9'(thr_q);
  assign has_word_o      = out_has_q;
  assign last_o          = out_last_q;
  assign too_wide_o      = ovf_q;
endmodule

FILE: sv/word_gap_segmenter_unit.sv
// top level of the word gap segmenter
// Usage: pixels of one text line arrive in column-major order, one per beat
// on pixel_i/column_end_i/line_end_i, taken at an edge where start is high
// and busy is low. column_end_i closes a column, line_end_i closes the line.
// After the line-end beat busy stays high while the back end makes three
// scans over the column store (one column bit per cycle from the memory
// read port) with two iterative divisions between them. Word results come
// out during the third scan, each held back until the next word closes, at
// most one per cycle; the final one, flagged by last, is produced by the
// flush state, and busy falls after that final beat.
// Results are shown for one cycle with result_valid_o high; the receiver
// cannot stall and must take every beat.
// A line with no words gives one beat with has_word clear.
// Config: foreground_value at apb byte address 0. The user must see that it
// is written only while idle; the block itself does not enforce this.
// Reset clears the control state and the foreground value; the column store
// needs no clearing since each line rewrites what it reads.
module word_gap_segmenter_unit #(
  parameter int unsigned MAX_COLUMNS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  pixel_i,
  input  logic        column_end_i,
  input  logic        line_end_i,
  output logic        result_valid_o,
  output logic [7:0]  word_left_o,
  output logic [7:0]  word_right_o,
  output logic [8:0]  gap_threshold_o,
  output logic        has_word_o,
  output logic        last_o,
  output logic        too_wide_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic              fg_q;
  logic [7:0]        fg_val_q;
  logic              accept;
  wgs_pkg::wgs_wr_t  wr;
  wgs_pkg::wgs_job_t job;

  assign accept = start && !busy;
  assign pready = 1'b1;
  assign prdata = (paddr == wgs_pkg::RegFgAddr) ? {24'd0, fg_val_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_val_q <= 8'd0;
      fg_q     <= 1'b0;
    end else begin
      fg_q <= 1'b0;
      if (psel && penable && pwrite && paddr == wgs_pkg::RegFgAddr) begin
        fg_val_q <= pwdata[7:0];
        fg_q     <= 1'b1;
      end
    end
  end

  wgs_front #(.MAX_COLUMNS(MAX_COLUMNS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .pixel_i      (pixel_i),
    .column_end_i (column_end_i),
    .line_end_i   (line_end_i),
    .fg_i         (fg_val_q),
    .wr_o         (wr),
    .job_o        (job)
  );

  wgs_back #(.MAX_COLUMNS(MAX_COLUMNS)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wr_i            (wr),
    .job_i           (job),
    .busy_o          (busy),
    .res_vld_o       (result_valid_o),
    .word_left_o     (word_left_o),
    .word_right_o    (word_right_o),
    .gap_threshold_o (gap_threshold_o),
    .has_word_o      (has_word_o),
    .last_o          (last_o),
    .too_wide_o      (too_wide_o)
  );

  a_line_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && line_end_i |=> busy)
    else $error("busy not raised after line end");

  a_result_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result outside busy window");

  a_no_word_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !has_word_o |-> last_o)
    else $error("empty result not final");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |=> !result_valid_o && !busy)
    else $error("output after last beat");

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fg_q |-> !$past(busy))
    else $error("config written while busy");
endmodule
